/* sv/lztf_pkg.sv */
// ----------------------------------------------------------------------------
// lztf_pkg
// Shared types, codes and reset constants for the LED zone twinkle fader.
// ----------------------------------------------------------------------------
package lztf_pkg;

	localparam int NUM_LEDS_DEF = 64;

	localparam logic KIND_RETARGET = 1'b0;
	localparam logic KIND_FRAME    = 1'b1;

	typedef enum logic [1:0] {
		CFG_FADE_STEP   = 2'd0,
		CFG_BRANCH_MASK = 2'd1,
		CFG_TRUNK_MASK  = 2'd2
	} cfg_idx_t;

	localparam logic [8:0]  FADE_STEP_RST   = 9'd13;
	localparam logic [63:0] BRANCH_MASK_RST = 64'h0000_1C63_8C67_31C0;
	localparam logic [63:0] TRUNK_MASK_RST  = 64'h0000_E000_0000_0038;
	localparam logic [8:0]  GB_RST          = 9'd255;
	localparam logic [8:0]  GB_MIN          = 9'd8;
	localparam logic [8:0]  GB_MAX          = 9'd256;
	localparam logic [8:0]  PROG_ONE        = 9'd256;

	typedef enum logic [1:0] {
		ZONE_OTHER,
		ZONE_BRANCH,
		ZONE_TRUNK
	} zone_t;

	typedef struct packed {
		logic [23:0] start_c;
		logic [23:0] target_c;
		logic [8:0]  prog;
		logic [23:0] shown_c;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RT_A,
		ST_RT_B,
		ST_RT_WR,
		ST_FRM_RD,
		ST_FRM_CALC
	} state_t;

	typedef struct packed {
		logic cap_rt;
		logic cap_frm;
		logic rd_en;
		logic rd_next;
		logic st1_en;
		logic st2_en;
		logic wr_rt;
		logic wr_frm;
		logic ld_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_frame;
		logic in_range;
		logic last_led;
		logic out_free;
	} dp_stat_t;

endpackage

/* sv/led_zone_twinkle_fader.sv */
// ----------------------------------------------------------------------------
// led_zone_twinkle_fader
// Per-LED crossfade engine: zone-based random retargeting and frame rendering.
// ----------------------------------------------------------------------------
// A retarget transfer occupies the block through accept, a two-stage color
// pipeline and a read-modify-write of the LED's state entry.
// A frame transfer has an accept step and a step to prime the state RAM read,
// then gives one pixel per cycle while the output is not stalled, a rate set
// by the single read port of the LED state RAM. The next input is taken as
// soon as the last pixel of a frame sits in the output register.
// All LED state comes up zero after reset without a clearing pass.
module led_zone_twinkle_fader import lztf_pkg::*; #(
	parameter int NUM_LEDS = NUM_LEDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [5:0]  led_select,
	input  logic [7:0]  rand_bright,
	input  logic [7:0]  rand_red,
	input  logic [7:0]  rand_green,
	input  logic [7:0]  rand_blue,
	input  logic [9:0]  light_level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  pixel_index,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        last
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	logic      ready;

	lztf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.cmd      (cmd),
		.ready    (ready)
	);

	lztf_dp #(
		.NUM_LEDS (NUM_LEDS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.kind        (kind),
		.led_select  (led_select),
		.rand_bright (rand_bright),
		.rand_red    (rand_red),
		.rand_green  (rand_green),
		.rand_blue   (rand_blue),
		.light_level (light_level),
		.cmd         (cmd),
		.stat        (stat),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.last        (last)
	);

	assign in_stall = ~ready;

endmodule

/* sv/lztf_ram.sv */
// ----------------------------------------------------------------------------
// lztf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lztf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/lztf_ctrl.sv */
// ----------------------------------------------------------------------------
// lztf_ctrl
// Sequencer for retarget and frame walk; drives datapath commands.
// ----------------------------------------------------------------------------
module lztf_ctrl import lztf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd,
	output logic      ready
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ready = 1'b1;
				if (in_valid) begin
					if (stat.in_frame) begin
						cmd.cap_frm = 1'b1;
						state_d     = ST_FRM_RD;
					end else if (stat.in_range) begin
						cmd.cap_rt = 1'b1;
						state_d    = ST_RT_A;
					end
				end
			end
			ST_RT_A: begin
				cmd.rd_en  = 1'b1;
				cmd.st1_en = 1'b1;
				state_d    = ST_RT_B;
			end
			ST_RT_B: begin
				cmd.st2_en = 1'b1;
				state_d    = ST_RT_WR;
			end
			ST_RT_WR: begin
				cmd.wr_rt = 1'b1;
				state_d   = ST_IDLE;
			end
			ST_FRM_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_FRM_CALC;
			end
			ST_FRM_CALC: begin
				if (stat.out_free) begin
					cmd.ld_out = 1'b1;
					cmd.wr_frm = 1'b1;
					if (stat.last_led) begin
						state_d = ST_IDLE;
					end else begin
						cmd.rd_en   = 1'b1;
						cmd.rd_next = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* sv/lztf_dp.sv */
// ----------------------------------------------------------------------------
// lztf_dp
// Datapath: config registers, target color pipeline, LED state RAM,
// crossfade arithmetic and output register.
// ----------------------------------------------------------------------------
module lztf_dp import lztf_pkg::*; #(
	parameter int NUM_LEDS = NUM_LEDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        kind,
	input  logic [5:0]  led_select,
	input  logic [7:0]  rand_bright,
	input  logic [7:0]  rand_red,
	input  logic [7:0]  rand_green,
	input  logic [7:0]  rand_blue,
	input  logic [9:0]  light_level,
	input  ctrl_cmd_t   cmd,
	output dp_stat_t    stat,
	input  logic        out_stall,
	output logic        out_valid,
	output logic [5:0]  pixel_index,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        last
);

	localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

	// floor(x / 255) for x below 2^16
	function automatic logic [8:0] div255(input logic [15:0] x);
		logic [16:0] sum;
		logic [8:0]  q;
		logic [16:0] r;
		sum = 17'(x) + 17'(x[15:8]);
		q   = sum[16:8];
		r   = 17'(x) - ({q, 8'h00} - 17'(q));
		return (r >= 17'd255) ? q + 9'd1 : q;
	endfunction

	function automatic logic [7:0] fade_ch(input logic [7:0] a, input logic [7:0] t,
		input logic [8:0] p);
		logic [7:0]  d;
		logic [16:0] acc;
		if (a > t) begin
			d   = a - t;
			acc = {1'b0, a, 8'h00} - 17'(d) * 17'(p);
		end else begin
			d   = t - a;
			acc = {1'b0, a, 8'h00} + 17'(d) * 17'(p);
		end
		acc = acc + 17'd128;
		return acc[15:8];
	endfunction

	logic [8:0]  fade_step_q;
	logic [63:0] branch_mask_q;
	logic [63:0] trunk_mask_q;
	logic [8:0]  gb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_step_q   <= FADE_STEP_RST;
			branch_mask_q <= BRANCH_MASK_RST;
			trunk_mask_q  <= TRUNK_MASK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FADE_STEP:   fade_step_q   <= cfg_data[8:0];
				CFG_BRANCH_MASK: branch_mask_q <= cfg_data;
				CFG_TRUNK_MASK:  trunk_mask_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [9:0] gb_clamp;
	always_comb begin
		if (light_level > 10'(GB_MAX)) begin
			gb_clamp = 10'(GB_MAX);
		end else if (light_level < 10'(GB_MIN)) begin
			gb_clamp = 10'(GB_MIN);
		end else begin
			gb_clamp = light_level;
		end
	end

	logic [AW-1:0] addr_q;
	logic [AW-1:0] raddr;

	assign raddr = cmd.rd_next ? addr_q + AW'(1) : addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gb_q   <= GB_RST;
			addr_q <= '0;
		end else begin
			if (cmd.cap_frm) begin
				gb_q   <= gb_clamp[8:0];
				addr_q <= '0;
			end else if (cmd.cap_rt) begin
				addr_q <= led_select[AW-1:0];
			end else if (cmd.rd_next) begin
				addr_q <= raddr;
			end
		end
	end

	// retarget input capture
	logic [5:0] led_q;
	logic [7:0] rb_q;
	logic [7:0] rr_q;
	logic [7:0] rg_q;
	logic [7:0] rbl_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_rt) begin
			led_q <= led_select;
			rb_q  <= rand_bright;
			rr_q  <= rand_red;
			rg_q  <= rand_green;
			rbl_q <= rand_blue;
		end
	end

	// stage 1: place channel in zone range, derive brightness
	zone_t           zone;
	logic [2:0][7:0] lo;
	logic [2:0][6:0] span;
	logic [2:0][7:0] rnd;
	logic [7:0]      bright;
	logic [2:0][7:0] v;
	logic [14:0]     rprod [3];
	logic [8:0]      b2;

	always_comb begin
		if (branch_mask_q[led_q]) begin
			zone = ZONE_BRANCH;
		end else if (trunk_mask_q[led_q]) begin
			zone = ZONE_TRUNK;
		end else begin
			zone = ZONE_OTHER;
		end
		case (zone)
			ZONE_BRANCH: begin
				lo     = {8'd0, 8'd200, 8'd0};
				span   = {7'd32, 7'd55, 7'd32};
				bright = rb_q;
			end
			ZONE_TRUNK: begin
				lo     = {8'd60, 8'd20, 8'd0};
				span   = {7'd20, 7'd10, 7'd10};
				bright = 8'd255;
			end
			default: begin
				lo     = {8'd200, 8'd0, 8'd0};
				span   = {7'd55, 7'd64, 7'd32};
				bright = rb_q;
			end
		endcase
		rnd = {rr_q, rg_q, rbl_q};
		for (int c = 0; c < 3; c++) begin
			rprod[c] = 15'(rnd[c]) * 15'(span[c]);
			v[c]     = lo[c] + 8'(rprod[c][14:8]);
		end
		b2 = div255(16'(17'(bright) * 17'(gb_q)));
	end

	logic [2:0][7:0] v_s1;
	logic [8:0]      b2_s1;

	always_ff @(posedge clk) begin
		if (cmd.st1_en) begin
			v_s1  <= v;
			b2_s1 <= b2;
		end
	end

	// stage 2: scale by brightness
	logic [2:0][7:0] tgt;
	logic [8:0]      tq [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			tq[c]  = div255(16'(17'(v_s1[c]) * 17'(b2_s1)));
			tgt[c] = tq[c][7:0];
		end
	end

	logic [2:0][7:0] tgt_s2;

	always_ff @(posedge clk) begin
		if (cmd.st2_en) begin
			tgt_s2 <= tgt;
		end
	end

	// LED state store; entries never written read as zero
	logic [NUM_LEDS-1:0] valid_q;
	logic                rd_valid_q;
	logic [ENTRY_W-1:0]  rd_raw;
	entry_t              rd_ent;
	entry_t              wr_ent;
	logic                wr_en;

	assign wr_en = cmd.wr_rt | cmd.wr_frm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[addr_q] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_valid_q <= valid_q[raddr];
			end
		end
	end

	lztf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_LEDS)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_q),
		.wdata (wr_ent),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rd_raw)
	);

	assign rd_ent = rd_valid_q ? entry_t'(rd_raw) : '0;

	// crossfade
	logic [23:0] faded;
	logic [9:0]  psum;
	logic [8:0]  p_next;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			faded[c*8 +: 8] = fade_ch(rd_ent.start_c[c*8 +: 8], rd_ent.target_c[c*8 +: 8],
				rd_ent.prog);
		end
		psum = 10'(rd_ent.prog) + 10'(fade_step_q);
		if (rd_ent.prog >= PROG_ONE) begin
			p_next = rd_ent.prog;
		end else if (psum > 10'(PROG_ONE)) begin
			p_next = PROG_ONE;
		end else begin
			p_next = psum[8:0];
		end
	end

	always_comb begin
		if (cmd.wr_frm) begin
			wr_ent.start_c  = rd_ent.start_c;
			wr_ent.target_c = rd_ent.target_c;
			wr_ent.prog     = p_next;
			wr_ent.shown_c  = faded;
		end else begin
			wr_ent.start_c  = rd_ent.shown_c;
			wr_ent.target_c = tgt_s2;
			wr_ent.prog     = '0;
			wr_ent.shown_c  = rd_ent.shown_c;
		end
	end

	// output register
	logic        out_valid_q;
	logic [5:0]  pix_q;
	logic [23:0] rgb_q;
	logic        last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			pix_q  <= 6'(addr_q);
			rgb_q  <= faded;
			last_q <= stat.last_led;
		end
	end

	assign stat.in_frame = (kind == KIND_FRAME);
	assign stat.in_range = {1'b0, led_select} < 7'(NUM_LEDS);
	assign stat.last_led = (addr_q == AW'(NUM_LEDS - 1));
	assign stat.out_free = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign pixel_index = pix_q;
	assign red         = rgb_q[23:16];
	assign green       = rgb_q[15:8];
	assign blue        = rgb_q[7:0];
	assign last        = last_q;

endmodule

/* sv/lztf_checker.sv */
// ----------------------------------------------------------------------------
// lztf_checker
// Port-level checks for the LED zone twinkle fader, bound to the top level.
// ----------------------------------------------------------------------------
module lztf_checker import lztf_pkg::*; #(
	parameter int NUM_LEDS = NUM_LEDS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       kind,
	input logic       out_valid,
	input logic       out_stall,
	input logic [5:0] pixel_index,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic       last
);

	// stalled pixel holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_index) && $stable(red)
			&& $stable(green) && $stable(blue) && $stable(last))
		else $error("stalled output pixel changed");

	// last marks exactly the final LED
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (pixel_index == 6'(NUM_LEDS - 1))))
		else $error("last flag does not match final LED index");

	// a frame transfer keeps the block busy on the next cycle
	a_frame_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && kind == KIND_FRAME |=> in_stall)
		else $error("input taken right after a frame transfer");

	// while a frame still has pixels to go, no input is taken
	a_mid_frame_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |-> in_stall)
		else $error("input ready in the middle of a frame");

endmodule

bind led_zone_twinkle_fader lztf_checker #(.NUM_LEDS(NUM_LEDS)) u_lztf_checker (.*);

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LED zone twinkle fader. Retarget and frame
// transfers are pushed through the input handshake while the pixel stream is
// compared against an in-bench model of the strip state (start, target, shown
// colors and fade progress per LED). A short directed table opens the run.
// Random traffic follows under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench;
	import lztf_pkg::*;

	localparam int LIMIT = 1_000_000;
	localparam int SETTLE = 8;
	localparam int DIR_ROWS = 20;
	localparam int PHASE_ITEMS = 68;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic       kind;
		logic [5:0] led;
		logic [7:0] bright;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [9:0] light;
	} strip_cmd_t;

	typedef struct packed {
		logic       black_known;
		strip_cmd_t cmd;
	} dir_row_t;

	typedef struct packed {
		logic [5:0] idx;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       last;
	} pixel_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic [5:0]  led_select;
	logic [7:0]  rand_bright;
	logic [7:0]  rand_red;
	logic [7:0]  rand_green;
	logic [7:0]  rand_blue;
	logic [9:0]  light_level;
	logic        out_valid;
	logic        out_stall;
	logic [5:0]  pixel_index;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        last;

	// strip model
	logic [23:0] from_color [NUM_LEDS_DEF];
	logic [23:0] to_color [NUM_LEDS_DEF];
	logic [23:0] lit_color [NUM_LEDS_DEF];
	logic [8:0]  progress [NUM_LEDS_DEF];
	logic [8:0]  ambient;
	logic [8:0]  step_q18;
	logic [63:0] branch_bits;
	logic [63:0] trunk_bits;

	pixel_t pending_pixels [$];
	int     mismatch_count = 0;
	int     cycle_count = 0;
	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;

	// black_known rows: every pixel of the frame is black
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{1'b1, '{KIND_FRAME,    6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 10'd1023}},
		'{1'b0, '{KIND_RETARGET, 6'd0,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 10'd0}},
		'{1'b0, '{KIND_RETARGET, 6'd3,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 10'd0}},
		'{1'b0, '{KIND_RETARGET, 6'd6,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 10'd0}},
		'{1'b0, '{KIND_RETARGET, 6'd63, 8'h00, 8'h00, 8'h00, 8'h00, 10'h3FF}},
		'{1'b0, '{KIND_RETARGET, 6'd1,  8'h00, 8'hFF, 8'hFF, 8'hFF, 10'd0}},
		'{1'b0, '{KIND_RETARGET, 6'd45, 8'h00, 8'h00, 8'h00, 8'h00, 10'd0}},
		'{1'b0, '{KIND_RETARGET, 6'd44, 8'hFF, 8'h00, 8'hFF, 8'h00, 10'd0}},
		'{1'b1, '{KIND_FRAME,    6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 10'd0}},
		'{1'b0, '{KIND_FRAME,    6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 10'd256}},
		'{1'b0, '{KIND_FRAME,    6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 10'd7}},
		'{1'b0, '{KIND_FRAME,    6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 10'd8}},
		'{1'b0, '{KIND_FRAME,    6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 10'd257}},
		'{1'b0, '{KIND_RETARGET, 6'd3,  8'h55, 8'hAA, 8'h55, 8'hAA, 10'd0}},
		'{1'b0, '{KIND_RETARGET, 6'd6,  8'h80, 8'h01, 8'hFE, 8'h80, 10'd0}},
		'{1'b0, '{KIND_FRAME,    6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 10'd200}},
		'{1'b0, '{KIND_FRAME,    6'd63, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 10'd100}},
		'{1'b0, '{KIND_RETARGET, 6'd2,  8'h7F, 8'h80, 8'h7F, 8'h80, 10'd0}},
		'{1'b0, '{KIND_FRAME,    6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 10'd512}},
		'{1'b0, '{KIND_FRAME,    6'd0,  8'h00, 8'h00, 8'h00, 8'h00, 10'd255}}
	};

	led_zone_twinkle_fader u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.led_select  (led_select),
		.rand_bright (rand_bright),
		.rand_red    (rand_red),
		.rand_green  (rand_green),
		.rand_blue   (rand_blue),
		.light_level (light_level),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.last        (last)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin : check_pixel
		pixel_t got;
		pixel_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {pixel_index, red, green, blue, last};
			if (pending_pixels.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected pixel: idx %0d rgb %02h%02h%02h last %0b",
						got.idx, got.r, got.g, got.b, got.last);
			end else begin
				want = pending_pixels.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("pixel mismatch: want idx %0d rgb %02h%02h%02h last %0b, got idx %0d rgb %02h%02h%02h last %0b",
							want.idx, want.r, want.g, want.b, want.last,
							got.idx, got.r, got.g, got.b, got.last);
				end
			end
		end
	end

	function automatic logic [7:0] zone_level(input int lo, input int hi,
			input logic [7:0] rnd, input int bright);
		int v;
		int b2;
		v = lo + ((int'(rnd) * (hi - lo)) >> 8);
		b2 = (bright * int'(ambient)) / 255;
		return 8'((v * b2) / 255);
	endfunction

	function automatic logic [7:0] blend_channel(input logic [7:0] a, input logic [7:0] t,
			input logic [8:0] p);
		int ia;
		int it;
		int ip;
		int v;
		ia = a;
		it = t;
		ip = p;
		if (ia == it)
			return a;
		if (ia > it)
			v = ia * 256 - (ia - it) * ip;
		else
			v = ia * 256 + (it - ia) * ip;
		return 8'((v + 128) >> 8);
	endfunction

	task automatic retarget_led(input strip_cmd_t c);
		zone_t z;
		logic [23:0] col;
		if (branch_bits[c.led])
			z = ZONE_BRANCH;
		else if (trunk_bits[c.led])
			z = ZONE_TRUNK;
		else
			z = ZONE_OTHER;
		case (z)
			ZONE_BRANCH: begin
				col = {zone_level(0, 32, c.r, c.bright), zone_level(200, 255, c.g, c.bright),
					zone_level(0, 32, c.b, c.bright)};
			end
			ZONE_TRUNK: begin
				col = {zone_level(60, 80, c.r, 255), zone_level(20, 30, c.g, 255),
					zone_level(0, 10, c.b, 255)};
			end
			default: begin
				col = {zone_level(200, 255, c.r, c.bright), zone_level(0, 64, c.g, c.bright),
					zone_level(0, 32, c.b, c.bright)};
			end
		endcase
		from_color[c.led] = lit_color[c.led];
		to_color[c.led] = col;
		progress[c.led] = '0;
	endtask

	task automatic render_frame(input logic [9:0] light, input bit black_known);
		pixel_t px;
		logic [23:0] s;
		logic [23:0] t;
		logic [23:0] c;
		logic [9:0] np;
		if (light > GB_MAX)
			ambient = GB_MAX;
		else if (light < GB_MIN)
			ambient = GB_MIN;
		else
			ambient = light[8:0];
		for (int i = 0; i < NUM_LEDS_DEF; i++) begin
			s = from_color[i];
			t = to_color[i];
			c = {blend_channel(s[23:16], t[23:16], progress[i]),
				blend_channel(s[15:8], t[15:8], progress[i]),
				blend_channel(s[7:0], t[7:0], progress[i])};
			if (progress[i] < PROG_ONE) begin
				np = progress[i] + step_q18;
				progress[i] = (np > PROG_ONE) ? PROG_ONE : np[8:0];
			end
			lit_color[i] = c;
			px.idx = i[5:0];
			px.r = black_known ? 8'h00 : c[23:16];
			px.g = black_known ? 8'h00 : c[15:8];
			px.b = black_known ? 8'h00 : c[7:0];
			px.last = (i == NUM_LEDS_DEF - 1);
			pending_pixels.push_back(px);
		end
	endtask

	task automatic send_cmd(input strip_cmd_t c, input bit black_known);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= c.kind;
		led_select <= c.led;
		rand_bright <= c.bright;
		rand_red <= c.r;
		rand_green <= c.g;
		rand_blue <= c.b;
		light_level <= c.light;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (c.kind == KIND_FRAME)
			render_frame(c.light, black_known);
		else
			retarget_led(c);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_FADE_STEP:   step_q18 = val[8:0];
			CFG_BRANCH_MASK: branch_bits = val;
			CFG_TRUNK_MASK:  trunk_bits = val;
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [63:0] fstep, input logic [63:0] bmask,
			input logic [63:0] tmask);
		write_reg(CFG_FADE_STEP, fstep);
		write_reg(CFG_BRANCH_MASK, bmask);
		write_reg(CFG_TRUNK_MASK, tmask);
		write_reg(CFG_UNUSED, {$urandom, $urandom});
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic strip_cmd_t random_cmd();
		strip_cmd_t c;
		c.kind = ($urandom_range(99) < 35) ? KIND_FRAME : KIND_RETARGET;
		c.led = 6'($urandom);
		c.bright = 8'($urandom);
		c.r = 8'($urandom);
		c.g = 8'($urandom);
		c.b = 8'($urandom);
		c.light = $urandom_range(1) ? 10'($urandom) : 10'($urandom_range(300));
		return c;
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = KIND_RETARGET;
		led_select = '0;
		rand_bright = '0;
		rand_red = '0;
		rand_green = '0;
		rand_blue = '0;
		light_level = '0;
		out_stall = 1'b0;
		step_q18 = FADE_STEP_RST;
		branch_bits = BRANCH_MASK_RST;
		trunk_bits = TRUNK_MASK_RST;
		ambient = GB_RST;
		for (int i = 0; i < NUM_LEDS_DEF; i++) begin
			from_color[i] = '0;
			to_color[i] = '0;
			lit_color[i] = '0;
			progress[i] = '0;
		end
		send_idle_pct = 21;
		recv_stall_pct = 84;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < DIR_ROWS; n++)
			send_cmd(dir_rows[n].cmd, dir_rows[n].black_known);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			send_idle_pct = (ph < 2) ? 21 : (ph < 4) ? 84 : 0;
			recv_stall_pct = (ph < 2) ? 84 : (ph < 4) ? 21 : 0;
			case (ph)
				0: load_settings(64'(PROG_ONE), {$urandom, $urandom}, {$urandom, $urandom});
				1: load_settings(64'd0, '1, '1);
				2: load_settings(64'h1FF, '0, '1);
				3: load_settings(64'($urandom_range(1, 64)), {$urandom, $urandom},
					{$urandom, $urandom});
				4: load_settings(64'(FADE_STEP_RST), BRANCH_MASK_RST, TRUNK_MASK_RST);
				default: load_settings(64'($urandom_range(300)), '0, '0);
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_cmd(random_cmd(), 1'b0);
			drain();
		end

		if (mismatch_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
